// ===== rtl/core/pplc_pkg.sv =====
// ----------------------------------------------------------------------------
// pplc_pkg
// Shared types and constants of the clamped PID position loop: fixed-point
// formats, register indexes, controller states and datapath commands.
// ----------------------------------------------------------------------------
package pplc_pkg;

  // Fixed-point formats: angles, errors and gains in Q(FracBits), scale in Q16.
  localparam int FracBits   = 8;
  localparam int ScaleFrac  = 16;
  localparam int DriveLimit = 127;

  // Field widths.
  localparam int AngleW = 24;
  localparam int GainW  = 16;
  localparam int RawW   = 16;
  localparam int IntegW = 32;
  localparam int DriveW = 8;

  // Configuration register file.
  localparam int NumRegs = 8;
  localparam int AddrW   = 5;
  localparam int DataW   = 32;

  typedef enum logic [2:0] {
    REG_SETPOINT     = 3'd0,
    REG_GAIN_P       = 3'd1,
    REG_GAIN_I       = 3'd2,
    REG_GAIN_D       = 3'd3,
    REG_DRIVE_ENABLE = 3'd4,
    REG_WINDUP_GUARD = 3'd5,
    REG_SENSOR_SCALE = 3'd6,
    REG_ANGLE_OFFSET = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [AngleW-1:0] setpoint;
    logic        [GainW-1:0]  gain_p;
    logic        [GainW-1:0]  gain_i;
    logic        [GainW-1:0]  gain_d;
    logic                     drive_enable;
    logic                     windup_guard;
    logic signed [AngleW-1:0] sensor_scale;
    logic signed [AngleW-1:0] angle_offset;
  } cfg_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_ERROR,
    ST_INTEG,
    ST_PROP,
    ST_DERIV,
    ST_DONE
  } state_t;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [1:0] {
    MUL_ANGLE,
    MUL_INTEG,
    MUL_PROP,
    MUL_DERIV
  } mul_sel_t;

  typedef struct packed {
    logic     capture_in;
    mul_sel_t mul_sel;
    logic     load_err;
    logic     load_integ;
    logic     load_acc;
    logic     add_acc;
    logic     finish;
  } cmd_t;

endpackage

// ===== rtl/core/pplc_regs.sv =====
// ----------------------------------------------------------------------------
// pplc_regs
// APB-style configuration register file of the PID position loop.
// ----------------------------------------------------------------------------
module pplc_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pplc_pkg::AddrW-1:0]  paddr,
  input  logic [pplc_pkg::DataW-1:0]  pwdata,
  output logic [pplc_pkg::DataW-1:0]  prdata,
  output pplc_pkg::cfg_t              cfg
);
  import pplc_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_idx_t'(paddr[AddrW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.setpoint     <= '0;
      cfg.gain_p       <= '0;
      cfg.gain_i       <= '0;
      cfg.gain_d       <= '0;
      cfg.drive_enable <= 1'b0;
      cfg.windup_guard <= 1'b0;
      cfg.sensor_scale <= 24'sd65536;
      cfg.angle_offset <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_SETPOINT:     cfg.setpoint     <= pwdata[AngleW-1:0];
        REG_GAIN_P:       cfg.gain_p       <= pwdata[GainW-1:0];
        REG_GAIN_I:       cfg.gain_i       <= pwdata[GainW-1:0];
        REG_GAIN_D:       cfg.gain_d       <= pwdata[GainW-1:0];
        REG_DRIVE_ENABLE: cfg.drive_enable <= pwdata[0];
        REG_WINDUP_GUARD: cfg.windup_guard <= pwdata[0];
        REG_SENSOR_SCALE: cfg.sensor_scale <= pwdata[AngleW-1:0];
        REG_ANGLE_OFFSET: cfg.angle_offset <= pwdata[AngleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_SETPOINT:     prdata = DataW'(cfg.setpoint);
      REG_GAIN_P:       prdata = DataW'(cfg.gain_p);
      REG_GAIN_I:       prdata = DataW'(cfg.gain_i);
      REG_GAIN_D:       prdata = DataW'(cfg.gain_d);
      REG_DRIVE_ENABLE: prdata = DataW'(cfg.drive_enable);
      REG_WINDUP_GUARD: prdata = DataW'(cfg.windup_guard);
      REG_SENSOR_SCALE: prdata = DataW'(cfg.sensor_scale);
      REG_ANGLE_OFFSET: prdata = DataW'(cfg.angle_offset);
      default:          prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/pplc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pplc_ctrl
// Sequencer of the PID position loop: input and output handshakes and the
// order in which the shared multiplier is used.
// ----------------------------------------------------------------------------
module pplc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output pplc_pkg::cmd_t cmd
);
  import pplc_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.mul_sel = MUL_ANGLE;
    case (state)
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.capture_in = in_valid;
        if (in_valid) begin
          state_next = ST_ANGLE;
        end
      end
      ST_ANGLE: begin
        cmd.mul_sel = MUL_ANGLE;
        state_next  = ST_ERROR;
      end
      ST_ERROR: begin
        cmd.load_err = 1'b1;
        cmd.mul_sel  = MUL_INTEG;
        state_next   = ST_INTEG;
      end
      ST_INTEG: begin
        cmd.load_integ = 1'b1;
        cmd.mul_sel    = MUL_PROP;
        state_next     = ST_PROP;
      end
      ST_PROP: begin
        cmd.load_acc = 1'b1;
        cmd.mul_sel  = MUL_DERIV;
        state_next   = ST_DERIV;
      end
      ST_DERIV: begin
        cmd.add_acc = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/pplc_dp.sv =====
// ----------------------------------------------------------------------------
// pplc_dp
// Datapath of the PID position loop: shared multiplier, error, integral,
// accumulator, drive saturation and the loop state.
// ----------------------------------------------------------------------------
module pplc_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  pplc_pkg::cmd_t                    cmd,
  input  pplc_pkg::cfg_t                    cfg,
  input  logic signed [pplc_pkg::RawW-1:0]  raw_reading,
  output logic signed [pplc_pkg::DriveW-1:0] drive_value,
  output logic                              drive_applied
);
  import pplc_pkg::*;

  localparam int MulW   = AngleW + 1;
  localparam int ProdW  = 2 * MulW;
  localparam int SumW   = ProdW + 1;
  localparam int AccW   = 46;
  localparam int TotW   = AccW + 1;
  localparam int AngleShift = ScaleFrac - FracBits;
  localparam int DriveShift = 2 * FracBits;

  localparam logic signed [SumW-1:0] ErrMax = SumW'((64'sd1 <<< (AngleW - 1)) - 1);
  localparam logic signed [SumW-1:0] ErrMin = SumW'(-(64'sd1 <<< (AngleW - 1)));
  localparam logic signed [SumW-1:0] IntMax = SumW'((64'sd1 <<< (IntegW - 1)) - 1);
  localparam logic signed [SumW-1:0] IntMin = SumW'(-(64'sd1 <<< (IntegW - 1)));
  localparam logic signed [IntegW-1:0] GuardMax = IntegW'(DriveLimit * (1 << FracBits));
  localparam logic signed [IntegW-1:0] GuardMin = IntegW'(-DriveLimit * (1 << FracBits));
  localparam logic signed [TotW-1:0] RoundBias = TotW'((64'sd1 <<< DriveShift) - 1);
  localparam logic signed [TotW-1:0] DriveMax  = TotW'(DriveLimit);
  localparam logic signed [TotW-1:0] DriveMin  = TotW'(-DriveLimit);

  logic signed [RawW-1:0]   raw_q;
  logic signed [AngleW-1:0] err_q;
  logic signed [AngleW-1:0] last_error;
  logic signed [IntegW-1:0] integral_sum;
  logic signed [AccW-1:0]   acc;
  logic signed [ProdW-1:0]  prod_q;

  logic signed [MulW-1:0]   mul_a;
  logic signed [MulW-1:0]   mul_b;
  logic signed [MulW-1:0]   diff;

  logic signed [SumW-1:0]   err_sum;
  logic signed [AngleW-1:0] err_sat;

  logic signed [SumW-1:0]   int_sum;
  logic signed [IntegW-1:0] int_sat;
  logic signed [IntegW-1:0] int_next;
  logic                     zero_cross;

  logic signed [TotW-1:0]   total;
  logic signed [TotW-1:0]   total_adj;
  logic signed [TotW-1:0]   drive_full;
  logic signed [DriveW-1:0] drive_sat;

  assign diff = MulW'(err_q) - MulW'(last_error);

  // Operand selection for the one shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MUL_ANGLE: begin
        mul_a = MulW'(raw_q);
        mul_b = MulW'(cfg.sensor_scale);
      end
      MUL_INTEG: begin
        mul_a = MulW'(last_error);
        mul_b = $signed(MulW'(cfg.gain_i));
      end
      MUL_PROP: begin
        mul_a = MulW'(err_q);
        mul_b = $signed(MulW'(cfg.gain_p));
      end
      MUL_DERIV: begin
        mul_a = diff;
        mul_b = $signed(MulW'(cfg.gain_d));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Error from the scaled angle, saturated to the angle width.
  always_comb begin
    err_sum = SumW'(cfg.setpoint) - SumW'(prod_q >>> AngleShift) + SumW'(cfg.angle_offset);
    if (err_sum > ErrMax) begin
      err_sat = AngleW'(ErrMax);
    end else if (err_sum < ErrMin) begin
      err_sat = AngleW'(ErrMin);
    end else begin
      err_sat = err_sum[AngleW-1:0];
    end
  end

  // Integral update, 32-bit saturation and the optional anti-windup rule.
  always_comb begin
    int_sum = SumW'(integral_sum) + SumW'(prod_q >>> FracBits);
    if (int_sum > IntMax) begin
      int_sat = IntegW'(IntMax);
    end else if (int_sum < IntMin) begin
      int_sat = IntegW'(IntMin);
    end else begin
      int_sat = int_sum[IntegW-1:0];
    end
    zero_cross = ((last_error <= 0) && (err_q >= 0)) || ((last_error >= 0) && (err_q <= 0));
    int_next = int_sat;
    if (cfg.windup_guard) begin
      if (int_sat > GuardMax) begin
        int_next = GuardMax;
      end else if (int_sat < GuardMin) begin
        int_next = GuardMin;
      end
      if (zero_cross) begin
        int_next = '0;
      end
    end
  end

  // Final sum, truncation toward zero and drive saturation.
  always_comb begin
    total      = TotW'(acc) + (TotW'(integral_sum) <<< FracBits);
    total_adj  = total[TotW-1] ? (total + RoundBias) : total;
    drive_full = total_adj >>> DriveShift;
    if (drive_full > DriveMax) begin
      drive_sat = DriveW'(DriveMax);
    end else if (drive_full < DriveMin) begin
      drive_sat = DriveW'(DriveMin);
    end else begin
      drive_sat = drive_full[DriveW-1:0];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    prod_q <= mul_a * mul_b;
    if (cmd.capture_in) begin
      raw_q <= raw_reading;
    end
    if (cmd.load_err) begin
      err_q <= err_sat;
    end
    if (cmd.load_acc) begin
      acc <= prod_q[AccW-1:0];
    end else if (cmd.add_acc) begin
      acc <= acc + prod_q[AccW-1:0];
    end
    if (cmd.finish) begin
      drive_value   <= drive_sat;
      drive_applied <= cfg.drive_enable;
    end
  end

  // Loop state.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_error   <= '0;
      integral_sum <= '0;
    end else begin
      if (cmd.load_integ) begin
        integral_sum <= int_next;
      end
      if (cmd.finish) begin
        last_error <= err_q;
      end
    end
  end

endmodule

// ===== rtl/core/pid_position_loop_clamped_top.sv =====
// ----------------------------------------------------------------------------
// pid_position_loop_clamped_top
// One PID position channel with output saturation and anti-windup.
// ----------------------------------------------------------------------------
// Usage: software programs the setpoint, the three gains, the sensor scale
// and offset, and the enable and anti-windup flags through the APB port
// while the loop is idle. Each control tick, the sensor sample is offered
// as one transaction on the input channel (in_valid, in_ready, raw_reading).
// The loop answers every input transaction with exactly one output
// transaction (out_valid, out_ready, drive_value, drive_applied).
// After acceptance the sequencer steps through ANGLE, ERROR, INTEG, PROP,
// DERIV and DONE, one sample at a time, as set by the single shared 25 x 25
// multiplier, which forms the scaled angle, the integral increment, the
// proportional term and the derivative term in turn.
// in_ready is high only while the sequencer waits for a sample.
// The result sits in an output register, so the next sample is accepted
// while a finished result still waits for the receiver. When the receiver
// stalls, the following result is held in the datapath until the output
// register frees up, and no further sample is taken meanwhile.
// Reset (synchronous, active high) restores the configuration registers to
// their defaults (sensor scale 1.0) and clears the stored error and integral.
// ----------------------------------------------------------------------------
module pid_position_loop_clamped_top (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration port.
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pplc_pkg::AddrW-1:0]         paddr,
  input  logic [pplc_pkg::DataW-1:0]         pwdata,
  output logic [pplc_pkg::DataW-1:0]         prdata,
  output logic                               pready,
  // Sample channel.
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [pplc_pkg::RawW-1:0]   raw_reading,
  // Drive channel.
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [pplc_pkg::DriveW-1:0] drive_value,
  output logic                               drive_applied
);
  import pplc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  // The register file never inserts wait states.
  assign pready = 1'b1;

  pplc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // The sequencer owns both handshakes and steps the datapath.
  pplc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // The datapath holds the loop state and the output payload register.
  pplc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg           (cfg),
    .raw_reading   (raw_reading),
    .drive_value   (drive_value),
    .drive_applied (drive_applied)
  );

endmodule

// ===== rtl/core/pplc_checker.sv =====
// ----------------------------------------------------------------------------
// pplc_checker
// Port-level checks of the PID position loop, bound to the top level.
// ----------------------------------------------------------------------------
module pplc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [pplc_pkg::DriveW-1:0] drive_value
);
  import pplc_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output transaction dropped while stalled");

  // The drive never leaves the symmetric saturation range.
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> drive_value != -DriveW'(DriveLimit + 1))
    else $error("drive outside saturation range");

  // No result is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // One sample at a time: an accepted sample closes the input side.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample accepted while busy");

endmodule

bind pid_position_loop_clamped_top pplc_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .drive_value (drive_value)
);

// ===== bench/pid_position_loop_clamped_top_tb.sv =====
// ----------------------------------------------------------------------------
// pid_position_loop_clamped_top_tb
// Self-checking bench for the clamped PID position loop. A directed table
// walks the corner cases (saturated error, angle flooring, drive truncation,
// integral saturation, anti-windup clamp and clear), then random phases
// drive sensor trajectories around the setpoint under several register
// settings. Drives are checked against typed-in values or a local predictor.
// ----------------------------------------------------------------------------
module pid_position_loop_clamped_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pplc_pkg::*;

  // Run shape.
  localparam int NumPhases     = 7;
  localparam int ItemsPerPhase = 200;
  localparam int SettleCycles  = 10;
  localparam int HoldoffCycles = 120;

  // Saturation bounds of the error, the integral and the anti-windup clamp.
  localparam longint ErrMax      = (longint'(1) <<< (AngleW - 1)) - 1;
  localparam longint ErrMin      = -ErrMax - 1;
  localparam longint IntegMax    = (longint'(1) <<< (IntegW - 1)) - 1;
  localparam longint IntegMin    = -IntegMax - 1;
  localparam longint WindupLimit = longint'(DriveLimit) <<< FracBits;

  // One drive transaction as seen on the output channel.
  typedef struct packed {
    logic signed [DriveW-1:0] value;
    logic                     applied;
  } drive_t;

  // One row of the directed table: either a register write or a sensor
  // sample. A sample row may carry a drive value typed in by hand.
  typedef struct packed {
    logic             is_write;
    reg_idx_t         idx;
    logic [DataW-1:0] value;
    logic             known;
    drive_t           want;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     psel    = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite  = 1'b0;
  logic [AddrW-1:0]         paddr   = '0;
  logic [DataW-1:0]         pwdata  = '0;
  logic [DataW-1:0]         prdata;
  logic                     pready;

  logic                     in_valid    = 1'b0;
  logic                     in_ready;
  logic signed [RawW-1:0]   raw_reading = '0;

  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DriveW-1:0] drive_value;
  logic                     drive_applied;

  // Predictor state: a shadow of the register file plus the loop memory.
  cfg_t   cfg_shadow;
  longint last_err_q8;
  longint integral_q8;

  // Drive results still owed by the block, oldest first.
  drive_t pending_drives [$];
  int     mismatch_count = 0;

  // The receiver counts long hold-offs on its own; the stimulus only asks.
  int     holdoff_asked = 0;
  int     holdoff_done  = 0;
  bit     rx_steady     = 1'b0;

  // Sensor trajectory used by the random part.
  int     walk_center;
  int     walk_pos;
  int     walk_step;

  step_t  directed_steps [];

  localparam logic signed [RawW-1:0] EdgeReadings [5] = '{
    16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001
  };

  pid_position_loop_clamped_top uut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .raw_reading   (raw_reading),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .drive_value   (drive_value),
    .drive_applied (drive_applied)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp64(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // Mirror a register write into the shadow copy; only the low bits of the
  // data word are kept, exactly as the register is wide.
  function automatic void shadow_write(reg_idx_t idx, logic [DataW-1:0] v);
    case (idx)
      REG_SETPOINT:     cfg_shadow.setpoint     = v[AngleW-1:0];
      REG_GAIN_P:       cfg_shadow.gain_p       = v[GainW-1:0];
      REG_GAIN_I:       cfg_shadow.gain_i       = v[GainW-1:0];
      REG_GAIN_D:       cfg_shadow.gain_d       = v[GainW-1:0];
      REG_DRIVE_ENABLE: cfg_shadow.drive_enable = v[0];
      REG_WINDUP_GUARD: cfg_shadow.windup_guard = v[0];
      REG_SENSOR_SCALE: cfg_shadow.sensor_scale = v[AngleW-1:0];
      REG_ANGLE_OFFSET: cfg_shadow.angle_offset = v[AngleW-1:0];
      default: ;
    endcase
  endfunction

  // Advance the loop by one sensor sample and return the drive it produces.
  // All arithmetic is done in 64 bits, which holds every intermediate term.
  function automatic drive_t pid_drive_next(logic signed [RawW-1:0] reading);
    longint counts, scale, sp, offset, gp, gi, gd;
    longint err_prev, err_now, angle_q8, sum, drive_now;
    drive_t res;
    counts   = reading;
    scale    = $signed(cfg_shadow.sensor_scale);
    sp       = $signed(cfg_shadow.setpoint);
    offset   = $signed(cfg_shadow.angle_offset);
    gp       = $unsigned(cfg_shadow.gain_p);
    gi       = $unsigned(cfg_shadow.gain_i);
    gd       = $unsigned(cfg_shadow.gain_d);
    err_prev = last_err_q8;

    // Q16 scale back to Q8 angle: arithmetic shift, so it floors.
    angle_q8 = (counts * scale) >>> (ScaleFrac - FracBits);
    err_now  = clamp64(sp - angle_q8 + offset, ErrMin, ErrMax);

    // The integral works on the previous error and saturates at 32 bits.
    integral_q8 = clamp64(integral_q8 + ((err_prev * gi) >>> FracBits),
                          IntegMin, IntegMax);
    if (cfg_shadow.windup_guard) begin
      integral_q8 = clamp64(integral_q8, -WindupLimit, WindupLimit);
      // Clear on a sign change of the error, including touching zero.
      if ((err_prev <= 0 && err_now >= 0) || (err_prev >= 0 && err_now <= 0))
        integral_q8 = 0;
    end

    sum = err_now * gp + (err_now - err_prev) * gd + (integral_q8 <<< FracBits);
    // Signed division truncates toward zero, which is what the drive wants.
    drive_now = clamp64(sum / (longint'(1) <<< (2 * FracBits)),
                        -DriveLimit, DriveLimit);
    last_err_q8 = err_now;

    res.value   = DriveW'(drive_now);
    res.applied = cfg_shadow.drive_enable;
    return res;
  endfunction

  function automatic step_t write_row(reg_idx_t idx, int value);
    step_t r;
    r = '0;
    r.is_write = 1'b1;
    r.idx      = idx;
    r.value    = value;
    return r;
  endfunction

  function automatic step_t sample_row(int reading);
    step_t r;
    r = '0;
    r.value = reading;
    return r;
  endfunction

  function automatic step_t known_row(int reading, int drive, bit applied);
    step_t r;
    r = sample_row(reading);
    r.known        = 1'b1;
    r.want.value   = DriveW'(drive);
    r.want.applied = applied;
    return r;
  endfunction

  // Random sensor reading: mostly a trajectory that is pulled toward the
  // setpoint and overshoots, so the error keeps changing sign; the rest is
  // noise and field extremes.
  function automatic logic signed [RawW-1:0] next_reading();
    int pick, nudge;
    pick = $urandom_range(0, 9);
    if (pick == 0)
      return RawW'($urandom);
    if (pick == 1)
      return EdgeReadings[$urandom_range(0, 4)];
    nudge = (walk_center - walk_pos) / 4
            + int'($urandom_range(0, 2 * walk_step)) - walk_step;
    walk_pos = int'(clamp64(walk_pos + nudge, -32768, 32767));
    return RawW'(walk_pos);
  endfunction

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input reg_idx_t idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_write(idx, value);
    @(posedge clk);
  endtask

  // Offer one sample and hold it until the block takes it. The expectation
  // is queued at the edge where the transaction completes.
  task automatic offer_sample(input logic signed [RawW-1:0] reading, input bit known,
                              input drive_t typed_in);
    drive_t predicted;
    in_valid    <= 1'b1;
    raw_reading <= reading;
    do @(posedge clk); while (!in_ready);
    predicted = pid_drive_next(reading);
    pending_drives.push_back(known ? typed_in : predicted);
  endtask

  // Sender gap whose length n must be at least one, with junk on the idle payload.
  task automatic pause_sender(input int n);
    in_valid    <= 1'b0;
    raw_reading <= RawW'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // Stop sending and wait until every owed drive has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Program all eight registers for one random phase. The setpoint is
  // derived from a target reading so that the trajectory brings the error
  // through zero again and again.
  task automatic program_phase(input int phase_idx);
    int scale, offset, target, gp, gi, gd, en, guard;
    longint aim;
    scale  = 65536;
    offset = 0;
    target = int'($urandom_range(0, 4000)) - 2000;
    gp     = $urandom_range(0, 65535);
    gi     = $urandom_range(0, 65535);
    gd     = $urandom_range(0, 65535);
    en     = $urandom_range(0, 1);
    guard  = $urandom_range(0, 1);
    case (phase_idx)
      0: begin
        // Well-behaved loop with anti-windup.
        gp = $urandom_range(256, 4096);
        gi = $urandom_range(0, 512);
        gd = $urandom_range(0, 1024);
        en = 1;
        guard = 1;
        offset = int'($urandom_range(0, 2048)) - 1024;
      end
      1: begin
        // Strong integral without the guard: the sum runs into saturation.
        gp = $urandom_range(0, 512);
        gi = $urandom_range(32768, 65535);
        gd = 0;
        en = 1;
        guard = 0;
      end
      2: begin
        // Everything at its extreme.
        gp = 65535;
        gi = 65535;
        gd = 65535;
        en = 1;
        scale = -8388608;
        offset = 8388607;
        target = int'($urandom_range(0, 20)) - 10;
      end
      3: begin
        // All gains off: the drive must stay at zero.
        gp = 0;
        gi = 0;
        gd = 0;
        en = 0;
        guard = 0;
        scale = 8388607;
      end
      4: begin
        scale  = int'($urandom_range(0, 16777215)) - 8388608;
        offset = int'($urandom_range(0, 16777215)) - 8388608;
      end
      5: begin
        gi = 65535;
        guard = 1;
        scale = int'($urandom_range(0, 262144)) - 131072;
      end
      default: begin
        scale  = -int'($urandom_range(1, 8388608));
        offset = int'($urandom_range(0, 16777215)) - 8388608;
        en = 0;
      end
    endcase
    aim = clamp64(((longint'(target) * scale) >>> (ScaleFrac - FracBits)) - offset,
                  ErrMin, ErrMax);
    write_reg(REG_SETPOINT, int'(aim));
    write_reg(REG_GAIN_P, gp);
    write_reg(REG_GAIN_I, gi);
    write_reg(REG_GAIN_D, gd);
    write_reg(REG_DRIVE_ENABLE, en);
    write_reg(REG_WINDUP_GUARD, guard);
    write_reg(REG_SENSOR_SCALE, scale);
    write_reg(REG_ANGLE_OFFSET, offset);
    walk_center = target;
    walk_pos    = target;
    walk_step   = $urandom_range(1, 64);
  endtask

  // Main stimulus: reset, the directed table, then the random phases.
  initial begin : stimulus
    int  burst_left;
    bit  gaps_on;
    cfg_shadow = '0;
    cfg_shadow.sensor_scale = 24'sd65536;
    last_err_q8 = 0;
    integral_q8 = 0;

    // Directed table. Rows with a typed-in drive are the ones whose answer
    // is obvious: zero gains after reset, and full-scale errors with a huge
    // proportional gain. Everything else goes through the predictor.
    directed_steps = '{
      known_row(0, 0, 0),
      // Most negative reading: the error saturates high, gains still zero.
      known_row(-32768, 0, 0),
      write_row(REG_GAIN_P, 'hFFFF),
      write_row(REG_DRIVE_ENABLE, 1),
      known_row(32767, -DriveLimit, 1),
      known_row(-32768, DriveLimit, 1),
      write_row(REG_GAIN_P, 256),
      sample_row(1),
      // Half a degree per count: a drive of -0.5 must truncate to zero.
      write_row(REG_SENSOR_SCALE, 32768),
      sample_row(1),
      sample_row(-3),
      // Tiny scale: a reading of -1 floors to an angle of -1, not 0.
      write_row(REG_SENSOR_SCALE, 1),
      sample_row(-1),
      sample_row(255),
      write_row(REG_SENSOR_SCALE, -8388608),
      sample_row(32767),
      sample_row(-32768),
      // Full-scale error with full integral gain: the integral pins at the
      // top of its 32-bit range, then swings down to the bottom.
      write_row(REG_SENSOR_SCALE, 65536),
      write_row(REG_SETPOINT, 8388607),
      write_row(REG_GAIN_I, 'hFFFF),
      write_row(REG_GAIN_D, 'hFFFF),
      sample_row(0),
      sample_row(0),
      sample_row(0),
      write_row(REG_SETPOINT, -8388608),
      sample_row(0),
      sample_row(0),
      sample_row(0),
      sample_row(0),
      // Anti-windup: the saturated integral gets clamped to the drive limit.
      write_row(REG_ANGLE_OFFSET, 8388607),
      write_row(REG_WINDUP_GUARD, 1),
      write_row(REG_GAIN_I, 256),
      write_row(REG_GAIN_P, 0),
      write_row(REG_GAIN_D, 0),
      sample_row(0),
      // Error crosses zero, touches zero, leaves zero, then stays negative.
      write_row(REG_SETPOINT, 0),
      write_row(REG_ANGLE_OFFSET, 0),
      sample_row(-4),
      sample_row(0),
      sample_row(4),
      sample_row(4),
      write_row(REG_DRIVE_ENABLE, 0),
      sample_row(4)
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_steps[k]) begin
      if (directed_steps[k].is_write) begin
        // Registers only change while the loop is idle.
        drain_results();
        write_reg(directed_steps[k].idx, directed_steps[k].value);
      end else begin
        offer_sample(directed_steps[k].value[RawW-1:0], directed_steps[k].known,
                     directed_steps[k].want);
      end
    end

    for (int phase_idx = 0; phase_idx < NumPhases; phase_idx++) begin
      drain_results();
      program_phase(phase_idx);
      // Phase 2 runs with no idling on either side.
      rx_steady  = (phase_idx == 2);
      gaps_on    = (phase_idx != 2);
      burst_left = 0;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (phase_idx == 0 && n == 40) begin
          // Long receiver hold-off while the sender keeps pushing: the
          // output register and the datapath fill and in_ready drops.
          holdoff_asked++;
        end
        if (phase_idx == 0 && n == 100) begin
          // Sender waits for the pipeline to empty completely.
          drain_results();
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (gaps_on && !(phase_idx == 0 && n >= 40 && n < 90)
              && $urandom_range(0, 3) != 0)
            pause_sender($urandom_range(1, 12));
        end
        burst_left--;
        offer_sample(next_reading(), 1'b0, '0);
      end
    end

    drain_results();
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Receiver: alternating ready and stall runs of random length, a steady
  // ready mode, and on request one long hold-off counted here.
  initial begin : receiver
    int hold_left;
    int run_left;
    bit stalling;
    hold_left = 0;
    run_left  = 0;
    stalling  = 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_done != holdoff_asked) begin
        holdoff_done = holdoff_asked;
        hold_left    = HoldoffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_steady) begin
        out_ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          stalling = !stalling;
          run_left = stalling ? $urandom_range(1, 6) : $urandom_range(1, 10);
        end
        run_left--;
        out_ready <= !stalling;
      end
    end
  end

  // Check every completed drive transaction against the oldest expectation.
  always @(posedge clk) begin : drive_check
    drive_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_drives.size() == 0) begin
        $display("%0t: unexpected drive transaction: expected none, got %0d/%0b",
                 $time, drive_value, drive_applied);
        mismatch_count++;
      end else begin
        want = pending_drives.pop_front();
        if (drive_value !== want.value) begin
          $display("%0t: drive_value: expected %0d, got %0d",
                   $time, want.value, drive_value);
          mismatch_count++;
        end
        if (drive_applied !== want.applied) begin
          $display("%0t: drive_applied: expected %0b, got %0b",
                   $time, want.applied, drive_applied);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #4ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
